// ----- rtl/core/agp_range_add_sum_tree_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros shared by the core modules
// Immediate-implication and next-cycle-implication forms, reset-gated.
// ----------------------------------------------------------------------------
`ifndef AGP_RANGE_ADD_SUM_TREE_TOP_ASSERT_SVH
`define AGP_RANGE_ADD_SUM_TREE_TOP_ASSERT_SVH

// same-cycle implication
`define AGP_ASSERT_IMP(LBL, CLK, RSTN, ANT, CON, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |-> (CON)) \
        else $error(MSG);

// next-cycle implication
`define AGP_ASSERT_NXT(LBL, CLK, RSTN, ANT, CON, MSG) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANT) |=> (CON)) \
        else $error(MSG);

`endif

// ----- rtl/core/agp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agp_pkg
// Widths, codes, controller/datapath command and status types, modular add.
// ----------------------------------------------------------------------------
package agp_pkg;

    localparam int LEAVES    = 1024;
    localparam int POS_W     = $clog2(LEAVES);
    localparam int CNT_W     = POS_W + 1;
    localparam int VAL_W     = 31;
    localparam int EXP_W     = 32;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [VAL_W-1:0] MOD_RST   = 31'd1000000007;
    localparam logic [VAL_W-1:0] RATIO_RST = 31'd1;
    localparam logic [CNT_W-1:0] CNT_RST   = CNT_W'(LEAVES);
    localparam logic [POS_W-1:0] POS_MAX   = POS_W'(LEAVES - 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD   = 2'd0,
        KIND_POW   = 2'd1,
        KIND_SUM   = 2'd2,
        KIND_WRITE = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULUS = 2'd0,
        CFG_RATIO   = 2'd1,
        CFG_COUNT   = 2'd2
    } t_cfg_idx;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR_INIT,
        OP_CLR_STEP,
        OP_Q_START,
        OP_Q_SAVE,
        OP_LOAD,
        OP_RED_START,
        OP_RED_SAVE,
        OP_ADD_MUL,
        OP_ADD_WR,
        OP_SUM_ACC,
        OP_PW_LD,
        OP_PW_MUL,
        OP_PW_SAVE,
        OP_PW_WR,
        OP_PT_WR,
        OP_OUT_LOAD
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic  cfg_hit;
        logic  clr_last;
        logic  mul_done;
        logic  idx_last;
        logic  bit_last;
        logic  empty;
        logic  pos_bad;
        t_kind kind;
        logic  out_busy;
    } t_dp_sts;

    // (a + b) mod m for a, b < m
    function automatic logic [VAL_W-1:0] f_mod_add(input logic [VAL_W-1:0] a,
                                                   input logic [VAL_W-1:0] b,
                                                   input logic [VAL_W-1:0] m);
        logic [VAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[VAL_W-1:0];
    endfunction

endpackage

// ----- rtl/core/agp_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agp_in_if
// Request channel: valid/ready with operation fields.
// ----------------------------------------------------------------------------
interface agp_in_if;
    logic                            valid;
    logic                            ready;
    logic [agp_pkg::KIND_W-1:0]      kind;
    logic [agp_pkg::POS_W-1:0]       first_pos;
    logic [agp_pkg::POS_W-1:0]       last_pos;
    logic [agp_pkg::VAL_W-1:0]       start_value;
    logic [agp_pkg::VAL_W-1:0]       step_value;
    logic [agp_pkg::EXP_W-1:0]       exponent;

    modport source (output valid, kind, first_pos, last_pos, start_value, step_value,
                    exponent, input ready);
    modport sink   (input valid, kind, first_pos, last_pos, start_value, step_value,
                    exponent, output ready);
endinterface

// ----- rtl/core/agp_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agp_out_if
// Result channel: valid/ready with the result value.
// ----------------------------------------------------------------------------
interface agp_out_if;
    logic                       valid;
    logic                       ready;
    logic [agp_pkg::VAL_W-1:0]  result_value;

    modport source (output valid, result_value, input ready);
    modport sink   (input valid, result_value, output ready);
endinterface

// ----- rtl/core/agp_modmul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agp_modmul
// Bit-serial modular multiplier: a * b mod m, a < m, one bit of b per cycle.
// ----------------------------------------------------------------------------
`include "agp_range_add_sum_tree_top_assert.svh"

module agp_modmul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [agp_pkg::VAL_W-1:0]  i_m,
    input  logic [agp_pkg::VAL_W-1:0]  i_a,
    input  logic [agp_pkg::VAL_W-1:0]  i_b,
    output logic                       o_done,
    output logic [agp_pkg::VAL_W-1:0]  o_prod
);

    localparam int STEP_W = $clog2(agp_pkg::VAL_W);

    logic                       r_busy;
    logic                       r_done;
    logic [STEP_W-1:0]          r_cnt;
    logic [agp_pkg::VAL_W-1:0]  r_a;
    logic [agp_pkg::VAL_W-1:0]  r_b;
    logic [agp_pkg::VAL_W-1:0]  r_m;
    logic [agp_pkg::VAL_W-1:0]  r_acc;
    logic [agp_pkg::VAL_W-1:0]  n_acc;

    // acc = 2*acc (+ a) mod m, MSB of b first
    always_comb begin
        n_acc = agp_pkg::f_mod_add(r_acc, r_acc, r_m);
        if (r_b[agp_pkg::VAL_W-1]) begin
            n_acc = agp_pkg::f_mod_add(n_acc, r_a, r_m);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= STEP_W'(agp_pkg::VAL_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_m   <= i_m;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[agp_pkg::VAL_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

    `AGP_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_start, !r_busy, "start while busy")
    `AGP_ASSERT_IMP(a_prod_range, i_clk, i_rst_n, r_done, r_acc < r_m, "product not reduced")
    `AGP_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done, "done longer than a cycle")

endmodule

// ----- rtl/core/agp_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agp_dp
// Datapath: element memory, config registers, operand registers, two modmuls,
// result register.
// ----------------------------------------------------------------------------
`include "agp_range_add_sum_tree_top_assert.svh"

module agp_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  agp_pkg::t_dp_cmd               i_cmd,
    output agp_pkg::t_dp_sts               o_sts,
    input  logic                           i_cfg_we,
    input  logic [agp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [agp_pkg::VAL_W-1:0]      i_cfg_data,
    input  logic [agp_pkg::KIND_W-1:0]     i_kind,
    input  logic [agp_pkg::POS_W-1:0]      i_first_pos,
    input  logic [agp_pkg::POS_W-1:0]      i_last_pos,
    input  logic [agp_pkg::VAL_W-1:0]      i_start_value,
    input  logic [agp_pkg::VAL_W-1:0]      i_step_value,
    input  logic [agp_pkg::EXP_W-1:0]      i_exponent,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [agp_pkg::VAL_W-1:0]      o_result_value
);

    localparam int BIT_W = $clog2(agp_pkg::EXP_W);

    // config
    logic [agp_pkg::VAL_W-1:0]  r_mod;
    logic [agp_pkg::VAL_W-1:0]  r_ratio;
    logic [agp_pkg::CNT_W-1:0]  r_cnt;
    logic                       cfg_hit;

    logic [agp_pkg::VAL_W-1:0]  m_eff;
    logic [agp_pkg::VAL_W-1:0]  one_m;
    logic [agp_pkg::CNT_W-1:0]  cnt_eff;
    logic [agp_pkg::CNT_W-1:0]  cnt_m1;
    logic [agp_pkg::POS_W-1:0]  last_clip;

    // item state
    agp_pkg::t_kind             r_kind;
    logic [agp_pkg::POS_W-1:0]  r_idx;
    logic [agp_pkg::POS_W-1:0]  r_last;
    logic                       r_empty;
    logic                       r_pos_bad;
    logic [agp_pkg::VAL_W-1:0]  r_s;
    logic [agp_pkg::VAL_W-1:0]  r_d;
    logic [agp_pkg::VAL_W-1:0]  r_u;
    logic [agp_pkg::VAL_W-1:0]  r_p;
    logic [agp_pkg::VAL_W-1:0]  r_q;
    logic [agp_pkg::VAL_W-1:0]  r_acc;
    logic [agp_pkg::EXP_W-1:0]  r_exp;
    logic [BIT_W-1:0]           r_bit;

    // element memory
    logic [agp_pkg::VAL_W-1:0]  r_mem [0:agp_pkg::LEAVES-1];
    logic [agp_pkg::VAL_W-1:0]  r_rd;
    logic                       mem_we;
    logic [agp_pkg::VAL_W-1:0]  mem_wd;

    // multipliers
    logic                       a_start, b_start;
    logic [agp_pkg::VAL_W-1:0]  a_a, a_b, b_a, b_b;
    logic                       a_done, b_done;
    logic [agp_pkg::VAL_W-1:0]  a_prod, b_prod;

    logic                       r_out_valid;
    logic [agp_pkg::VAL_W-1:0]  r_out_data;

    assign m_eff   = (r_mod == '0) ? agp_pkg::VAL_W'(1) : r_mod;
    assign one_m   = (m_eff == agp_pkg::VAL_W'(1)) ? '0 : agp_pkg::VAL_W'(1);
    assign cnt_eff = (r_cnt == '0) ? agp_pkg::CNT_W'(1) :
                     (r_cnt > agp_pkg::CNT_RST) ? agp_pkg::CNT_RST : r_cnt;
    assign cnt_m1  = cnt_eff - 1'b1;
    assign last_clip = ({1'b0, i_last_pos} > cnt_m1) ? cnt_m1[agp_pkg::POS_W-1:0] : i_last_pos;

    assign cfg_hit = i_cfg_we && ((i_cfg_idx == agp_pkg::CFG_MODULUS) ||
                                  (i_cfg_idx == agp_pkg::CFG_RATIO) ||
                                  (i_cfg_idx == agp_pkg::CFG_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod   <= agp_pkg::MOD_RST;
            r_ratio <= agp_pkg::RATIO_RST;
            r_cnt   <= agp_pkg::CNT_RST;
        end else if (i_cfg_we) begin
            case (agp_pkg::t_cfg_idx'(i_cfg_idx))
                agp_pkg::CFG_MODULUS: r_mod   <= i_cfg_data;
                agp_pkg::CFG_RATIO:   r_ratio <= i_cfg_data;
                agp_pkg::CFG_COUNT:   r_cnt   <= i_cfg_data[agp_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // operand steering
    always_comb begin
        a_start = 1'b0;
        b_start = 1'b0;
        a_a     = one_m;
        a_b     = r_ratio;
        b_a     = one_m;
        b_b     = r_d;
        case (i_cmd.op)
            agp_pkg::OP_Q_START: begin
                a_start = 1'b1;
            end
            agp_pkg::OP_RED_START: begin
                a_start = 1'b1;
                b_start = 1'b1;
                a_b     = r_s;
            end
            agp_pkg::OP_ADD_MUL: begin
                a_start = 1'b1;
                b_start = 1'b1;
                a_a     = r_u;
                a_b     = r_p;
                b_a     = r_p;
                b_b     = r_q;
            end
            agp_pkg::OP_PW_MUL: begin
                a_start = 1'b1;
                b_start = 1'b1;
                a_a     = r_acc;
                a_b     = r_p;
                b_a     = r_p;
                b_b     = r_p;
            end
            default: ;
        endcase
    end

    // memory write port
    always_comb begin
        mem_we = 1'b0;
        mem_wd = '0;
        case (i_cmd.op)
            agp_pkg::OP_CLR_STEP: mem_we = 1'b1;
            agp_pkg::OP_ADD_WR: begin
                mem_we = 1'b1;
                mem_wd = agp_pkg::f_mod_add(r_rd, a_prod, m_eff);
            end
            agp_pkg::OP_PW_WR: begin
                mem_we = 1'b1;
                mem_wd = r_acc;
            end
            agp_pkg::OP_PT_WR: begin
                mem_we = 1'b1;
                mem_wd = r_s;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_idx] <= mem_wd;
        end
        r_rd <= r_mem[r_idx];
    end

    agp_modmul u_mul_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (a_start),
        .i_m     (m_eff),
        .i_a     (a_a),
        .i_b     (a_b),
        .o_done  (a_done),
        .o_prod  (a_prod)
    );

    agp_modmul u_mul_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (b_start),
        .i_m     (m_eff),
        .i_a     (b_a),
        .i_b     (b_b),
        .o_done  (b_done),
        .o_prod  (b_prod)
    );

    // working registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            agp_pkg::OP_CLR_INIT: r_idx <= '0;
            agp_pkg::OP_CLR_STEP: r_idx <= r_idx + 1'b1;
            agp_pkg::OP_Q_SAVE:   r_q   <= a_prod;
            agp_pkg::OP_LOAD: begin
                r_kind    <= agp_pkg::t_kind'(i_kind);
                r_idx     <= i_first_pos;
                r_last    <= last_clip;
                r_empty   <= i_first_pos > last_clip;
                r_pos_bad <= {1'b0, i_first_pos} >= cnt_eff;
                r_s       <= i_start_value;
                r_d       <= i_step_value;
                r_exp     <= i_exponent;
                r_acc     <= '0;
            end
            agp_pkg::OP_RED_SAVE: begin
                r_s <= a_prod;
                r_d <= b_prod;
                r_u <= a_prod;
                r_p <= one_m;
            end
            agp_pkg::OP_ADD_WR: begin
                r_p <= b_prod;
                r_u <= agp_pkg::f_mod_add(r_u, r_d, m_eff);
                if (r_idx != r_last) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            agp_pkg::OP_SUM_ACC: begin
                r_acc <= agp_pkg::f_mod_add(r_acc, r_rd, m_eff);
                if (r_idx != r_last) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            agp_pkg::OP_PW_LD: begin
                r_p   <= r_rd;
                r_acc <= one_m;
                r_bit <= '0;
            end
            agp_pkg::OP_PW_SAVE: begin
                if (r_exp[0]) begin
                    r_acc <= a_prod;
                end
                r_p   <= b_prod;
                r_exp <= r_exp >> 1;
                r_bit <= r_bit + 1'b1;
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == agp_pkg::OP_OUT_LOAD) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == agp_pkg::OP_OUT_LOAD) begin
            r_out_data <= r_acc;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_data;

    assign o_sts.cfg_hit  = cfg_hit;
    assign o_sts.clr_last = (r_idx == agp_pkg::POS_MAX);
    assign o_sts.mul_done = a_done;
    assign o_sts.idx_last = (r_idx == r_last);
    assign o_sts.bit_last = (r_bit == BIT_W'(agp_pkg::EXP_W - 1));
    assign o_sts.empty    = r_empty;
    assign o_sts.pos_bad  = r_pos_bad;
    assign o_sts.kind     = r_kind;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    `AGP_ASSERT_IMP(a_wr_in_range, i_clk, i_rst_n,
        mem_we && (i_cmd.op != agp_pkg::OP_CLR_STEP), {1'b0, r_idx} < cnt_eff,
        "element write outside active array")
    `AGP_ASSERT_IMP(a_out_reduced, i_clk, i_rst_n,
        i_cmd.op == agp_pkg::OP_OUT_LOAD, r_acc < m_eff, "result not reduced")
    `AGP_ASSERT_IMP(a_mul_pair, i_clk, i_rst_n, b_done, a_done, "multipliers out of step")

endmodule

// ----- rtl/core/agp_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agp_ctrl
// Sequencer: clearing pass, ratio reduction, per-kind element loops, result.
// ----------------------------------------------------------------------------
module agp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  agp_pkg::t_dp_sts  i_sts,
    output agp_pkg::t_dp_cmd  o_cmd,
    input  logic              i_in_valid,
    output logic              o_in_ready
);

    typedef enum logic [17:0] {
        S_CLR_INIT  = 18'h00001,
        S_CLEAR     = 18'h00002,
        S_Q_START   = 18'h00004,
        S_Q_WAIT    = 18'h00008,
        S_IDLE      = 18'h00010,
        S_RED_START = 18'h00020,
        S_RED_WAIT  = 18'h00040,
        S_DISPATCH  = 18'h00080,
        S_ADD_MUL   = 18'h00100,
        S_ADD_WAIT  = 18'h00200,
        S_ADD_WR    = 18'h00400,
        S_SUM_ACC   = 18'h00800,
        S_SUM_WAIT  = 18'h01000,
        S_PW_MUL    = 18'h02000,
        S_PW_WAIT   = 18'h04000,
        S_PW_WR     = 18'h08000,
        S_PT_WR     = 18'h10000,
        S_DONE      = 18'h20000
    } t_state;

    t_state r_state, n_state;
    agp_pkg::t_dp_op op;

    always_comb begin
        n_state = r_state;
        op      = agp_pkg::OP_NONE;
        case (r_state)
            S_CLR_INIT: begin
                op      = agp_pkg::OP_CLR_INIT;
                n_state = S_CLEAR;
            end
            S_CLEAR: begin
                op = agp_pkg::OP_CLR_STEP;
                if (i_sts.clr_last) begin
                    n_state = S_Q_START;
                end
            end
            S_Q_START: begin
                op      = agp_pkg::OP_Q_START;
                n_state = S_Q_WAIT;
            end
            S_Q_WAIT: begin
                if (i_sts.mul_done) begin
                    op      = agp_pkg::OP_Q_SAVE;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    op      = agp_pkg::OP_LOAD;
                    n_state = S_RED_START;
                end
            end
            S_RED_START: begin
                op      = agp_pkg::OP_RED_START;
                n_state = S_RED_WAIT;
            end
            S_RED_WAIT: begin
                if (i_sts.mul_done) begin
                    op      = agp_pkg::OP_RED_SAVE;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_sts.kind)
                    agp_pkg::KIND_ADD: n_state = i_sts.empty ? S_DONE : S_ADD_MUL;
                    agp_pkg::KIND_SUM: n_state = i_sts.empty ? S_DONE : S_SUM_ACC;
                    agp_pkg::KIND_POW: begin
                        if (i_sts.pos_bad) begin
                            n_state = S_DONE;
                        end else begin
                            op      = agp_pkg::OP_PW_LD;
                            n_state = S_PW_MUL;
                        end
                    end
                    default: n_state = i_sts.pos_bad ? S_DONE : S_PT_WR;
                endcase
            end
            S_ADD_MUL: begin
                op      = agp_pkg::OP_ADD_MUL;
                n_state = S_ADD_WAIT;
            end
            S_ADD_WAIT: begin
                if (i_sts.mul_done) begin
                    n_state = S_ADD_WR;
                end
            end
            S_ADD_WR: begin
                op      = agp_pkg::OP_ADD_WR;
                n_state = i_sts.idx_last ? S_DONE : S_ADD_MUL;
            end
            S_SUM_ACC: begin
                op      = agp_pkg::OP_SUM_ACC;
                n_state = i_sts.idx_last ? S_DONE : S_SUM_WAIT;
            end
            S_SUM_WAIT: begin
                n_state = S_SUM_ACC;
            end
            S_PW_MUL: begin
                op      = agp_pkg::OP_PW_MUL;
                n_state = S_PW_WAIT;
            end
            S_PW_WAIT: begin
                if (i_sts.mul_done) begin
                    op      = agp_pkg::OP_PW_SAVE;
                    n_state = i_sts.bit_last ? S_PW_WR : S_PW_MUL;
                end
            end
            S_PW_WR: begin
                op      = agp_pkg::OP_PW_WR;
                n_state = S_DONE;
            end
            S_PT_WR: begin
                op      = agp_pkg::OP_PT_WR;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    op      = agp_pkg::OP_OUT_LOAD;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLR_INIT;
        endcase
        // a register write restarts the clearing pass
        if (i_sts.cfg_hit) begin
            op      = agp_pkg::OP_NONE;
            n_state = S_CLR_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.op   = op;
    assign o_in_ready = (r_state == S_IDLE) && !i_sts.cfg_hit;

endmodule

// ----- rtl/core/agp_range_add_sum_tree_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// agp_range_add_sum_tree_top
// Modular array with progression range add, point power, range sum and
// point write.
// ----------------------------------------------------------------------------
// One item at a time; every item returns one result. All products go through
// a bit-serial modular multiplier (one bit per cycle, two running side by side),
// which sets the cost. Every kind first reduces start/step mod modulus; then
// range add runs both multipliers once per element of the clipped range, range
// sum only reads and adds up each element, point power squares and multiplies
// once per bit of the 32-bit exponent, and point write stores one element.
// After reset and after every register write a clearing pass zeroes all 1024
// elements and reduces ratio before the first transfer is taken. A finished
// result waits in an output register, so the next request is accepted while
// the result is still unclaimed.
// ----------------------------------------------------------------------------
module agp_range_add_sum_tree_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    agp_in_if.sink                         i_in,
    agp_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [agp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [agp_pkg::VAL_W-1:0]      i_cfg_data
);

    agp_pkg::t_dp_cmd cmd;
    agp_pkg::t_dp_sts sts;

    // sequencer: decides what the datapath does each cycle
    agp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready)
    );

    // element store, config, multipliers and result register
    agp_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_in.kind),
        .i_first_pos    (i_in.first_pos),
        .i_last_pos     (i_in.last_pos),
        .i_start_value  (i_in.start_value),
        .i_step_value   (i_in.step_value),
        .i_exponent     (i_in.exponent),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_result_value (o_out.result_value)
    );

endmodule
